/* rtl/mwm_pkg.sv */
`default_nettype none

package mwm_pkg;

  // Internal coordinate width: holds 0..63, enough for a neighbor of the last cell
  localparam int COORD_W = 6;

  localparam logic [7:0] WALL_N = 8'h01;
  localparam logic [7:0] WALL_E = 8'h02;
  localparam logic [7:0] WALL_S = 8'h04;
  localparam logic [7:0] WALL_W = 8'h08;

  // The four goal cells form the square {7,8} x {7,8}
  localparam logic [COORD_W-1:0] GOAL_LO = COORD_W'(7);
  localparam logic [COORD_W-1:0] GOAL_HI = COORD_W'(8);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_RD,
    ST_MOD
  } state_t;

  typedef enum logic [2:0] {
    STEP_C,
    STEP_N,
    STEP_S,
    STEP_E,
    STEP_W
  } step_t;

  // Distance along one axis to the nearer of the two goal coordinates
  function automatic logic [7:0] axis_dist(input logic [COORD_W-1:0] c);
    logic [7:0] d;
    if (c < GOAL_LO) begin
      d = 8'(GOAL_LO - c);
    end else if (c > GOAL_HI) begin
      d = 8'(c - GOAL_HI);
    end else begin
      d = 8'd0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/maze_wall_map_store_unit.sv */
`default_nettype none

// Channel  | Ports                                   | Transaction
// ---------+-----------------------------------------+------------------------------
// command  | start, busy, cell_x, cell_y, mark_bits  | start high, busy low at edge
// result   | done, cell_marks, cell_distance, at_goal| done high for one cycle
//
// After reset the block is busy while it fills
// every cell with its goal distance and clears the marks.
// An item inside the grid does one read-modify-write (a read state, then a write state) on the single
// memory port for the cell plus one per mirrored wall toward an existing neighbor, all while busy.
// The result strobe comes in the cycle after the last write, with busy low.
// An item outside the grid gives a zero result in the next cycle, never busy.
// The receiver cannot stall; each result is shown for exactly one cycle.

module maze_wall_map_store_unit
  import mwm_pkg::*;
#(
  parameter int GRID_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] cell_x,
  input  logic [3:0] cell_y,
  input  logic [7:0] mark_bits,
  output logic       done,
  output logic [7:0] cell_marks,
  output logic [7:0] cell_distance,
  output logic       at_goal
);

  localparam int DEPTH = GRID_WIDTH * GRID_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = 2 * COORD_W;
  localparam logic [COORD_W-1:0] GW_C = COORD_W'(GRID_WIDTH);
  localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_WIDTH - 1);

  state_t              state, state_next;
  step_t               cur_step, pick_step, sel_step;
  logic [4:0]          pending, pending_clr;
  logic [COORD_W-1:0]  item_x, item_y, fill_x, fill_y;
  logic [7:0]          item_bits;

  logic [COORD_W-1:0]  in_x, in_y, cx, cy;
  logic [7:0]          or_bits;
  logic                accept, in_grid;
  logic [FW-1:0]       addr_full;
  logic [AW-1:0]       ram_addr;
  logic                ram_we;
  logic [15:0]         ram_wdata, ram_rdata;
  logic [7:0]          fill_dist;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_x   = COORD_W'(cell_x);
  assign in_y   = COORD_W'(cell_y);
  assign in_grid = (in_x < GW_C) && (in_y < GW_C);

  // Lowest pending access goes first
  always_comb begin
    if (pending[0]) begin
      pick_step = STEP_C;
    end else if (pending[1]) begin
      pick_step = STEP_N;
    end else if (pending[2]) begin
      pick_step = STEP_S;
    end else if (pending[3]) begin
      pick_step = STEP_E;
    end else begin
      pick_step = STEP_W;
    end
  end

  assign sel_step = (state == ST_MOD) ? cur_step : pick_step;

  always_comb begin
    pending_clr = pending;
    pending_clr[cur_step] = 1'b0;
  end

  // Cell coordinates and the bits ORed in for the selected access
  always_comb begin
    cx      = item_x;
    cy      = item_y;
    or_bits = item_bits;
    unique case (sel_step)
      STEP_C: begin
        or_bits = item_bits;
      end
      STEP_N: begin
        cy      = item_y + COORD_W'(1);
        or_bits = WALL_S;
      end
      STEP_S: begin
        cy      = item_y - COORD_W'(1);
        or_bits = WALL_N;
      end
      STEP_E: begin
        cx      = item_x + COORD_W'(1);
        or_bits = WALL_W;
      end
      STEP_W: begin
        cx      = item_x - COORD_W'(1);
        or_bits = WALL_E;
      end
      default: begin
        or_bits = item_bits;
      end
    endcase
    if (state == ST_FILL) begin
      cx = fill_x;
      cy = fill_y;
    end
  end

  assign addr_full = FW'(cx) * FW'(GRID_WIDTH) + FW'(cy);
  assign ram_addr  = addr_full[AW-1:0];
  assign fill_dist = axis_dist(fill_x) + axis_dist(fill_y);
  assign ram_we    = (state == ST_FILL) || (state == ST_MOD);
  assign ram_wdata = (state == ST_FILL) ? {fill_dist, 8'h00}
                                        : {ram_rdata[15:8], ram_rdata[7:0] | or_bits};

  mwm_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (fill_x == LAST && fill_y == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_grid) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_MOD;
      end
      ST_MOD: begin
        state_next = (pending_clr == 5'd0) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_x  <= '0;
      fill_y  <= '0;
      pending <= '0;
      done    <= 1'b0;
    end else begin
      done <= ((state == ST_MOD) && (pending_clr == 5'd0)) || (accept && !in_grid);
      if (state == ST_FILL) begin
        // advance row-major: y inner, x outer
        if (fill_y == LAST) begin
          fill_y <= '0;
          fill_x <= fill_x + COORD_W'(1);
        end else begin
          fill_y <= fill_y + COORD_W'(1);
        end
      end
      if (accept && in_grid) begin
        pending[0] <= 1'b1;
        pending[1] <= mark_bits[0] && (in_y != LAST);
        pending[2] <= mark_bits[2] && (in_y != '0);
        pending[3] <= mark_bits[1] && (in_x != LAST);
        pending[4] <= mark_bits[3] && (in_x != '0);
      end else if (state == ST_MOD) begin
        pending <= pending_clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_x    <= in_x;
      item_y    <= in_y;
      item_bits <= mark_bits;
    end
    if (state == ST_RD) begin
      cur_step <= pick_step;
    end
    if (accept && !in_grid) begin
      cell_marks    <= 8'd0;
      cell_distance <= 8'd0;
      at_goal       <= 1'b0;
    end else if (state == ST_MOD && cur_step == STEP_C) begin
      cell_marks    <= ram_rdata[7:0] | item_bits;
      cell_distance <= ram_rdata[15:8];
      at_goal       <= (item_x == GOAL_LO || item_x == GOAL_HI) &&
                       (item_y == GOAL_LO || item_y == GOAL_HI);
    end
  end

  // A result strobe follows only the last write of an item or an out-of-grid command
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_MOD) || $past(start && !busy))
    else $error("result strobe without a finished transaction");

  // The write-back targets the entry read in the previous cycle
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> (ram_addr == $past(ram_addr)))
    else $error("read-modify-write address changed between read and write");

  // No access is left over once the block is idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pending == 5'd0))
    else $error("pending access while idle");

  // While accesses remain pending, the write state returns to the read state
  a_mod_to_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) && (pending_clr != 5'd0) |=> (state == ST_RD))
    else $error("sequence dropped a pending access");

endmodule

`default_nettype wire

/* rtl/mwm_cell_ram.sv */
`default_nettype none

module mwm_cell_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // Single port, read-first, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
